// File: sv/ted_pkg.sv
// Shared types and constants for the transposition edit distance block.
`timescale 1ns / 1ps
package ted_pkg;
	localparam int MaxLen = 64;
	localparam int CntW = $clog2(MaxLen + 1);
	localparam int IdxW = $clog2(MaxLen);
	localparam int DistW = 7;
	localparam int DistMax = 127;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FIRST = 2'd0;
	localparam kind_t KIND_SECOND = 2'd1;
	localparam kind_t KIND_COMPUTE = 2'd2;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

	// Data a cell hands to its right neighbor each cycle; dd is the entry two rows up
	// and two columns left of the receiving cell
	typedef struct packed {
		logic             vld;
		logic [7:0]       a;
		logic [7:0]       a_prev;
		logic [CntW-1:0]  i;
		logic [CntW-1:0]  left;
		logic [CntW-1:0]  diag;
		logic [CntW-1:0]  dd;
	} cell_link_t;
endpackage

// File: sv/ted_if.sv
// Valid/ready channel interfaces for input and result beats.
`timescale 1ns / 1ps
interface ted_in_if (input logic clk);
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] char_byte;
	modport source (output valid, kind, char_byte, input ready);
	modport sink (input valid, kind, char_byte, output ready);
endinterface

interface ted_out_if (input logic clk);
	logic valid;
	logic ready;
	logic [6:0] distance;
	logic overflow;
	modport source (output valid, distance, overflow, input ready);
	modport sink (input valid, distance, overflow, output ready);
endinterface

// File: sv/ted_cell.sv
// One column cell of the systolic distance array: works on one second-string byte.
`timescale 1ns / 1ps
module ted_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic [ted_pkg::CntW-1:0] col,
	input  logic [7:0]          b,
	input  logic [7:0]          b_prev,
	input  ted_pkg::cell_link_t lin,
	output ted_pkg::cell_link_t lout
);
	import ted_pkg::*;

	logic [CntW-1:0] up_q;
	logic [CntW-1:0] dd_q;
	logic [CntW-1:0] d1, d2, d3, best, val;
	cell_link_t out_q;

	// Evaluate one table entry for row lin.i, column col
	always_comb begin
		d1 = up_q + 1'b1;
		d2 = lin.left + 1'b1;
		d3 = lin.diag + 1'b1;
		best = (d1 < d2) ? d1 : d2;
		best = (best < d3) ? best : d3;
		if (lin.i > CntW'(1) && col > CntW'(1) && lin.a == b_prev && lin.a_prev == b
				&& (lin.dd + 1'b1) < best)
			best = lin.dd + 1'b1;
		val = (lin.a == b) ? lin.diag : best;
	end

	// Pass the row to the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (clr) begin
			out_q.vld <= 1'b0;
		end else begin
			out_q.vld <= lin.vld;
			if (lin.vld) begin
				out_q.a <= lin.a;
				out_q.a_prev <= lin.a_prev;
				out_q.i <= lin.i;
				out_q.left <= val;
				out_q.diag <= up_q;
				out_q.dd <= dd_q;
			end
		end
	end

	// Hold this column's last row and the left column's entry from the row before
	always_ff @(posedge clk) begin
		if (clr) begin
			up_q <= col;
		end else if (lin.vld) begin
			up_q <= val;
			dd_q <= lin.diag;
		end
	end

	assign lout = out_q;
endmodule

// File: sv/transposition_edit_distance.sv
// Top level of the optimal string alignment distance block.
`timescale 1ns / 1ps
// Load beats (kind 0 or 1) are taken one per cycle, also while a finished
// result waits in its output register. A compute beat starts a sweep through
// a chain of MaxLen cells, one per second-string character: rows enter cell 1
// in order and ripple right one cell a cycle, so a compute holds the input
// until the bottom row has passed column n2 and the result has been taken
// into the output register; a result still waiting from the previous compute
// adds its stall. Characters past MaxLen are dropped and flagged. No beat is
// taken during a sweep.
module transposition_edit_distance (
	input logic         clk,
	input logic         arst_n,
	ted_in_if.sink      in_ch,
	ted_out_if.source   out_ch
);
	import ted_pkg::*;

	logic [7:0] first_q [MaxLen];
	logic [7:0] second_q [MaxLen];
	logic [CntW-1:0] n1_q, n2_q, row_q;
	logic [CntW:0] tick_q;
	logic ovf_q;
	state_t st_q, st_d;
	logic [DistW-1:0] dist_q;
	logic res_ovf_q;
	logic clr;
	logic acc;
	logic emit;
	logic [7:0] a_q, a_prev_q;
	cell_link_t feed;
	cell_link_t link [MaxLen+1];
	logic [CntW-1:0] res_val;

	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign clr = acc && in_ch.kind == KIND_COMPUTE;
	assign emit = (st_q == ST_OUT) && (!out_ch.valid || out_ch.ready);

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (clr) st_d = ST_RUN;
			ST_RUN:  if (tick_q == {1'b0, n1_q} + {1'b0, n2_q} + (CntW+1)'(1)) st_d = ST_OUT;
			ST_OUT:  if (emit) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Feed rows into the chain
	always_comb begin
		feed.vld = (st_q == ST_RUN) && row_q <= n1_q && row_q != '0;
		feed.a = a_q;
		feed.a_prev = a_prev_q;
		feed.i = row_q;
		feed.left = row_q;
		feed.diag = row_q - 1'b1;
		feed.dd = row_q - 2'd2;
	end
	assign link[0] = feed;

	for (genvar g = 0; g < MaxLen; g++) begin : g_cell
		logic [7:0] bp;
		assign bp = (g == 0) ? 8'd0 : second_q[(g == 0) ? 0 : g - 1];
		ted_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clr(clr),
			.col(CntW'(g + 1)), .b(second_q[g]), .b_prev(bp),
			.lin(link[g]), .lout(link[g+1])
		);
	end

	// Final value: bottom row at column n2 (column 0 when n2 is zero)
	logic [CntW-1:0] last_q;
	always_ff @(posedge clk) begin
		if (link[n2_q].vld && link[n2_q].i == n1_q)
			last_q <= link[n2_q].left;
	end
	assign res_val = (n2_q == '0) ? n1_q : (n1_q == '0) ? n2_q : last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			n1_q <= '0;
			n2_q <= '0;
			ovf_q <= 1'b0;
			row_q <= '0;
			tick_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			// Append characters
			if (acc && in_ch.kind == KIND_FIRST) begin
				if (n1_q < CntW'(MaxLen)) n1_q <= n1_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (acc && in_ch.kind == KIND_SECOND) begin
				if (n2_q < CntW'(MaxLen)) n2_q <= n2_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (clr) begin
				row_q <= CntW'(1);
				tick_q <= '0;
			end
			if (st_q == ST_RUN) begin
				tick_q <= tick_q + 1'b1;
				if (row_q <= n1_q) row_q <= row_q + 1'b1;
			end
			// Emit and clear
			if (emit) begin
				n1_q <= '0;
				n2_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_ch.kind == KIND_FIRST && n1_q < CntW'(MaxLen))
			first_q[IdxW'(n1_q)] <= in_ch.char_byte;
		if (acc && in_ch.kind == KIND_SECOND && n2_q < CntW'(MaxLen))
			second_q[IdxW'(n2_q)] <= in_ch.char_byte;
		// Fetch the first-string byte of the next row in the cycle before it is fed
		if (clr) begin
			a_q <= first_q[0];
		end else if (st_q == ST_RUN && row_q <= n1_q) begin
			a_q <= first_q[IdxW'(row_q)];
			a_prev_q <= a_q;
		end
		if (emit) begin
			dist_q <= (res_val > CntW'(DistMax)) ? DistW'(DistMax) : DistW'(res_val);
			res_ovf_q <= ovf_q;
		end
	end

	assign out_ch.distance = dist_q;
	assign out_ch.overflow = res_ovf_q;

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !in_ch.ready) else $error("input taken mid sweep");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OUT |=> out_ch.valid) else $error("result not raised");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n1_q <= CntW'(MaxLen) && n2_q <= CntW'(MaxLen)) else $error("count overrun");
`endif
endmodule

// File: tb/transposition_edit_distance_test.sv
// Testbench for the optimal string alignment distance block: predicts each distance and checks it.
`timescale 1ns / 1ps
module transposition_edit_distance_test;
	import ted_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_byte;
	} load_beat_t;

	typedef struct packed {
		logic [6:0] distance;
		logic       overflow;
	} dist_result_t;

	logic clk;
	logic arst_n;

	ted_in_if in_ch (clk);
	ted_out_if out_ch (clk);

	transposition_edit_distance dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Predictor state
	logic [7:0] str_a [MaxLen];
	logic [7:0] str_b [MaxLen];
	int         len_a;
	int         len_b;
	bit         dropped_char;

	load_beat_t   pending_beats [$];
	dist_result_t expected_dists [$];
	int  errors;
	int  computes_checked;
	int  overflow_results;
	bit  stim_done;
	bit  hold_sender;
	int  send_wait;
	int  recv_wait;
	bit  in_took;
	bit  out_took;

	// Restricted Damerau-Levenshtein distance over the loaded strings
	function automatic int osa_dist();
		int prev2 [MaxLen + 1];
		int prev1 [MaxLen + 1];
		int cur [MaxLen + 1];
		int best;
		for (int j = 0; j <= len_b; j++) begin
			prev1[j] = j;
			prev2[j] = 0;
		end
		for (int i = 1; i <= len_a; i++) begin
			cur[0] = i;
			for (int j = 1; j <= len_b; j++) begin
				if (str_a[i-1] == str_b[j-1]) begin
					cur[j] = prev1[j-1];
				end else begin
					best = prev1[j] + 1;
					if (cur[j-1] + 1 < best) best = cur[j-1] + 1;
					if (prev1[j-1] + 1 < best) best = prev1[j-1] + 1;
					if (i > 1 && j > 1 && str_a[i-1] == str_b[j-2] &&
							str_a[i-2] == str_b[j-1] && prev2[j-2] + 1 < best)
						best = prev2[j-2] + 1;
					cur[j] = best;
				end
			end
			prev2 = prev1;
			prev1 = cur;
		end
		return (prev1[len_b] > DistMax) ? DistMax : prev1[len_b];
	endfunction

	// Apply one accepted beat to the predictor
	task automatic predict_beat(input load_beat_t b);
		dist_result_t r;
		case (b.kind)
			KIND_FIRST: begin
				if (len_a < MaxLen) begin
					str_a[len_a] = b.char_byte;
					len_a++;
				end else dropped_char = 1;
			end
			KIND_SECOND: begin
				if (len_b < MaxLen) begin
					str_b[len_b] = b.char_byte;
					len_b++;
				end else dropped_char = 1;
			end
			KIND_COMPUTE: begin
				r.distance = 7'(osa_dist());
				r.overflow = dropped_char;
				expected_dists.push_back(r);
				len_a = 0;
				len_b = 0;
				dropped_char = 0;
			end
			default: ;
		endcase
	endtask

	// Queue a string pair then a compute
	task automatic queue_pair(input int na, input int nb, input int alpha);
		load_beat_t b;
		int order;
		int ia;
		int ib;
		ia = 0;
		ib = 0;
		while (ia < na || ib < nb) begin
			order = $urandom_range(0, 1);
			if ((order == 0 && ia < na) || ib >= nb) begin
				b.kind = KIND_FIRST;
				ia++;
			end else begin
				b.kind = KIND_SECOND;
				ib++;
			end
			b.char_byte = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1));
			pending_beats.push_back(b);
		end
		b.kind = KIND_COMPUTE;
		b.char_byte = 8'($urandom);
		pending_beats.push_back(b);
	endtask

	task automatic queue_one(input logic [1:0] k, input logic [7:0] c);
		load_beat_t b;
		b.kind = k;
		b.char_byte = c;
		pending_beats.push_back(b);
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end

	// Driver: present beats at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.kind <= KIND_FIRST;
			in_ch.char_byte <= 0;
			send_wait <= 0;
		end else if (in_ch.valid && !in_took) begin
			// hold the beat
		end else if (send_wait > 0) begin
			in_ch.valid <= 0;
			send_wait <= send_wait - 1;
		end else if (pending_beats.size() > 0 && !hold_sender) begin
			in_ch.valid <= 1;
			{in_ch.kind, in_ch.char_byte} <= pending_beats.pop_front();
			send_wait <= $urandom_range(0, 3) * $urandom_range(0, 1);
		end else begin
			in_ch.valid <= 0;
		end
	end

	// Ready for results, stalled at random after each beat
	always @(negedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			out_ch.ready <= 0;
			recv_wait <= 0;
		end else if (recv_wait > 0) begin
			out_ch.ready <= 0;
			recv_wait <= recv_wait - 1;
		end else if (out_took) begin
			w = $urandom_range(0, 3) * $urandom_range(0, 1);
			out_ch.ready <= (w == 0);
			recv_wait <= (w == 0) ? 0 : w - 1;
		end else begin
			out_ch.ready <= 1;
		end
	end

	// Monitor: predict accepted beats and check results
	always @(posedge clk) begin
		dist_result_t want;
		in_took = arst_n && in_ch.valid && in_ch.ready;
		out_took = arst_n && out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				predict_beat({in_ch.kind, in_ch.char_byte});
			if (out_ch.valid && out_ch.ready) begin
				if (expected_dists.size() == 0) begin
					$display("%0t: unexpected result distance=%0d overflow=%0d",
						$time, out_ch.distance, out_ch.overflow);
					errors++;
				end else begin
					want = expected_dists.pop_front();
					computes_checked++;
					if (want.overflow) overflow_results++;
					if (want.distance !== out_ch.distance) begin
						$display("%0t: distance expected %0d actual %0d",
							$time, want.distance, out_ch.distance);
						errors++;
					end
					if (want.overflow !== out_ch.overflow) begin
						$display("%0t: overflow expected %0d actual %0d",
							$time, want.overflow, out_ch.overflow);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int n;
		int sel;
		errors = 0;
		computes_checked = 0;
		overflow_results = 0;
		len_a = 0;
		len_b = 0;
		dropped_char = 0;
		hold_sender = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty strings, one empty, swap, extremes, unused kind, overflow
		queue_one(KIND_COMPUTE, 8'hff);
		queue_one(KIND_FIRST, 8'h00);
		queue_one(KIND_COMPUTE, 8'h00);
		queue_one(KIND_SECOND, 8'hff);
		queue_one(KIND_COMPUTE, 8'h00);
		queue_one(KIND_FIRST, 8'h00);
		queue_one(KIND_FIRST, 8'hff);
		queue_one(KIND_SECOND, 8'hff);
		queue_one(KIND_SECOND, 8'h00);
		queue_one(2'd3, 8'h55);
		queue_one(KIND_COMPUTE, 8'haa);
		queue_one(KIND_FIRST, 8'h80);
		queue_one(KIND_SECOND, 8'h7f);
		queue_one(KIND_COMPUTE, 8'h00);
		// full length both strings, distinct bytes, maximum distance
		for (int k = 0; k < MaxLen; k++) queue_one(KIND_FIRST, 8'h01);
		for (int k = 0; k < MaxLen; k++) queue_one(KIND_SECOND, 8'h02);
		queue_one(KIND_COMPUTE, 8'h00);
		// overflow on each string
		for (int k = 0; k < MaxLen + 2; k++) queue_one(KIND_FIRST, 8'($urandom));
		queue_one(KIND_COMPUTE, 8'h00);
		for (int k = 0; k < MaxLen + 1; k++) queue_one(KIND_SECOND, 8'($urandom));
		queue_one(KIND_COMPUTE, 8'h00);

		// Pause until every result has come
		wait (pending_beats.size() == 0 && !in_ch.valid);
		wait (expected_dists.size() == 0);
		hold_sender = 1;
		repeat (2 * MaxLen + 10) @(posedge clk);
		hold_sender = 0;

		// Random: mostly short strings over small alphabets, some noise
		n = 0;
		while (n < 1150) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				queue_one(2'($urandom_range(0, 3)), 8'($urandom));
				n++;
			end else begin
				int na;
				int nb;
				if (sel == 1) begin
					na = $urandom_range(MaxLen - 2, MaxLen + 2);
					nb = $urandom_range(0, MaxLen + 1);
				end else begin
					na = $urandom_range(0, 8);
					nb = $urandom_range(0, 8);
				end
				queue_pair(na, nb, (sel < 10) ? 3 : ((sel < 16) ? 6 : 256));
				n += na + nb + 1;
			end
			wait (pending_beats.size() < 50);
		end

		wait (pending_beats.size() == 0 && !in_ch.valid);
		wait (expected_dists.size() == 0);
		repeat (2 * MaxLen + 10) @(posedge clk);
		$display("Checked %0d distances (%0d with overflow) over random and directed strings.",
			computes_checked, overflow_results);
		if (errors == 0 && expected_dists.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
